// ----- rtl/itrs_pkg.sv -----
// ============================================================================
// itrs_pkg
// Shared constants, types and helpers for the integer to radix text converter.
// ============================================================================
`default_nettype none

package itrs_pkg;

  localparam int WORD_BITS   = 32;
  localparam int RADIX_W     = 6;
  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 6;
  localparam int STORE_DEPTH = 32;
  localparam int IDX_W       = $clog2(STORE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DIV_CNT_W   = $clog2(WORD_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DECIMAL   = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHR_ALPHA = 8'h41;
  localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;

  // Divider result and status, one bundle from the divider to the sequencer
  typedef struct packed {
    logic                 done;
    logic [WORD_BITS-1:0] quotient;
    logic [RADIX_W-1:0]   remainder;
  } div_res_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (d < DECIMAL) begin
      digit_char = CHR_ZERO + d_ext;
    end else begin
      digit_char = CHR_ALPHA + d_ext - {{(CHAR_W-RADIX_W){1'b0}}, DECIMAL};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/itrs_ram.sv -----
// ============================================================================
// itrs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
`default_nettype none

module itrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/itrs_div.sv -----
// ============================================================================
// itrs_div
// Restoring divider: word by radix, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module itrs_div
  import itrs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] dividend,
  input  wire logic [RADIX_W-1:0]   divisor,
  output      div_res_t             res
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_BITS-1:0] quo;
  logic [RADIX_W-1:0]   rem;
  logic [RADIX_W-1:0]   dvs;

  logic [RADIX_W:0]     trial;
  logic [RADIX_W:0]     diff;
  logic                 ge;

  assign trial = {rem, quo[WORD_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_CNT_W'(WORD_BITS - 1);
      quo  <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quo <= {quo[WORD_BITS-2:0], ge};
      rem <= ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
      cnt <= cnt - DIV_CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign res.done      = done;
  assign res.quotient  = quo;
  assign res.remainder = rem;

endmodule

`default_nettype wire

// ----- rtl/integer_to_radix_string.sv -----
// Each digit takes one pass of the shared bit-serial divider plus a handoff to the
// next pass. A leading minus is sent from S_SIGN before the digits are read back;
// each digit then goes out through S_RDADDR and S_LOAD, which waits on output stall.
// One conversion runs at a time, up to 32 binary digits; item_stall is high until S_IDLE.
// Reset: clears the sequencer, divider control and output valid; the digit store is
// not cleared, each entry is written before it is read.
// ============================================================================
// integer_to_radix_string
// Converts a 32-bit integer (signed in decimal only) to ASCII text in radix 2..36, MSB first.
// ============================================================================
`default_nettype none

module integer_to_radix_string
  import itrs_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output      logic                        item_stall,
  input  wire logic signed [WORD_BITS-1:0] value,
  input  wire logic        [RADIX_W-1:0]   radix,
  output      logic                        char_valid,
  input  wire logic                        char_stall,
  output      logic        [CHAR_W-1:0]    char_code,
  output      logic                        last_char,
  output      logic        [LEN_W-1:0]     text_length
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DIV    = 5'b00010,
    S_SIGN   = 5'b00100,
    S_RDADDR = 5'b01000,
    S_LOAD   = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [RADIX_W-1:0] radix_q, radix_q_next;
  logic               neg, neg_next;
  logic [CNT_W-1:0]   digit_count, digit_count_next;
  logic [IDX_W-1:0]   rd_idx, rd_idx_next;
  logic [LEN_W-1:0]   total, total_next;

  logic               char_valid_next;
  logic [CHAR_W-1:0]  char_code_next;
  logic               last_char_next;
  logic [LEN_W-1:0]   text_length_next;

  logic                 accept;
  logic                 out_free;
  logic [RADIX_W-1:0]   radix_clamp;
  logic                 neg_in;
  logic [WORD_BITS-1:0] value_u;
  logic [WORD_BITS-1:0] mag_in;
  logic [CNT_W-1:0]     count_inc;

  logic                 div_start;
  logic [WORD_BITS-1:0] div_dividend;
  logic [RADIX_W-1:0]   div_divisor;
  div_res_t             div_res;

  logic                 ram_we;
  logic                 ram_re;
  logic [RADIX_W-1:0]   ram_rdata;

  assign item_stall = rst | (state != S_IDLE);
  assign accept     = item_valid & ~item_stall;
  assign out_free   = ~char_valid | ~char_stall;

  assign radix_clamp = (radix < RADIX_MIN) ? RADIX_MIN :
                       (radix > RADIX_MAX) ? RADIX_MAX : radix;
  assign value_u     = value;
  assign neg_in      = (radix_clamp == DECIMAL) & value_u[WORD_BITS-1];
  assign mag_in      = neg_in ? (~value_u + WORD_BITS'(1)) : value_u;
  assign count_inc   = digit_count + CNT_W'(1);

  itrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .res      (div_res)
  );

  itrs_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (digit_count[IDX_W-1:0]),
    .wdata (div_res.remainder),
    .re    (ram_re),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next       = state;
    radix_q_next     = radix_q;
    neg_next         = neg;
    digit_count_next = digit_count;
    rd_idx_next      = rd_idx;
    total_next       = total;
    div_start        = 1'b0;
    div_dividend     = mag_in;
    div_divisor      = radix_q;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    char_valid_next  = char_valid & char_stall;
    char_code_next   = char_code;
    last_char_next   = last_char;
    text_length_next = text_length;

    case (state)
      S_IDLE: begin
        div_divisor = radix_clamp;
        if (accept) begin
          radix_q_next     = radix_clamp;
          neg_next         = neg_in;
          digit_count_next = '0;
          div_start        = 1'b1;
          state_next       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          ram_we           = 1'b1;
          digit_count_next = count_inc;
          if ((div_res.quotient != '0) && (count_inc < CNT_W'(STORE_DEPTH))) begin
            // keep dividing the quotient
            div_start    = 1'b1;
            div_dividend = div_res.quotient;
          end else begin
            rd_idx_next = digit_count[IDX_W-1:0];
            total_next  = LEN_W'(count_inc) + LEN_W'(neg);
            state_next  = neg ? S_SIGN : S_RDADDR;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          char_valid_next  = 1'b1;
          char_code_next   = CHR_MINUS;
          last_char_next   = (total == LEN_W'(1));
          text_length_next = (total == LEN_W'(1)) ? total : '0;
          state_next       = S_RDADDR;
        end
      end
      S_RDADDR: begin
        ram_re     = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        // read data holds until the next read, so wait here for the output
        if (out_free) begin
          char_valid_next  = 1'b1;
          char_code_next   = digit_char(ram_rdata);
          last_char_next   = (rd_idx == '0);
          text_length_next = (rd_idx == '0) ? total : '0;
          if (rd_idx == '0) begin
            state_next = S_IDLE;
          end else begin
            rd_idx_next = rd_idx - IDX_W'(1);
            state_next  = S_RDADDR;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      char_valid  <= 1'b0;
      neg         <= 1'b0;
      digit_count <= '0;
    end else begin
      state       <= state_next;
      char_valid  <= char_valid_next;
      neg         <= neg_next;
      digit_count <= digit_count_next;
    end
  end

  always_ff @(posedge clk) begin
    radix_q     <= radix_q_next;
    rd_idx      <= rd_idx_next;
    total       <= total_next;
    char_code   <= char_code_next;
    last_char   <= last_char_next;
    text_length <= text_length_next;
  end

endmodule

`default_nettype wire

// ----- rtl/itrs_checker.sv -----
// ============================================================================
// itrs_checker
// Port-level checks on the integer to radix text converter.
// ============================================================================
`default_nettype none

module itrs_checker
  import itrs_pkg::*;
(
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        item_valid,
  input wire logic                        item_stall,
  input wire logic                        char_valid,
  input wire logic                        char_stall,
  input wire logic        [CHAR_W-1:0]    char_code,
  input wire logic                        last_char,
  input wire logic        [LEN_W-1:0]     text_length
);

  // a held character must not change under stall
  a_char_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_code)
      && $stable(last_char) && $stable(text_length))
    else $error("character changed while stalled");

  // a new request is never taken right after one was accepted
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("request accepted while a conversion is running");

  // length is carried on the last character only, and is never zero there
  a_len_on_last: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (last_char ? (text_length != '0) : (text_length == '0)))
    else $error("text length does not match last flag");

  // a minus sign is always followed by at least one digit
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    char_valid && (char_code == CHR_MINUS) |-> !last_char)
    else $error("minus sign given as last character");

endmodule

bind integer_to_radix_string itrs_checker u_itrs_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: integer to radix text converter testbench
// Drives signed integers and radices into the converter, predicts the ASCII
// text of each request and checks every returned character in order, under
// several patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import itrs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_TICKS = 200;
  localparam int PHASE_ITEMS  = 34;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [RADIX_W-1:0]   radix;
  } request_t;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic [LEN_W-1:0]  length;
  } text_char_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        item_valid = 1'b0;
  logic                        item_stall;
  logic signed [WORD_BITS-1:0] value = '0;
  logic        [RADIX_W-1:0]   radix = '0;
  logic                        char_valid;
  logic                        char_stall = 1'b0;
  logic        [CHAR_W-1:0]    char_code;
  logic                        last_char;
  logic        [LEN_W-1:0]     text_length;

  request_t   pending_requests[$];
  text_char_t expected_chars[$];
  request_t   next_req;
  text_char_t want_char;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         mismatches = 0;
  int         cycles = 0;

  integer_to_radix_string dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .value      (value),
    .radix      (radix),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last_char  (last_char),
    .text_length(text_length)
  );

  always #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
    mismatches++;
  endtask

  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last,
                                    input int total);
    text_char_t c;
    c.code   = code;
    c.last   = last;
    c.length = last ? LEN_W'(total) : '0;
    expected_chars.push_back(c);
  endfunction

  // Queue the characters that one request should produce.
  function automatic void predict_text(input logic [WORD_BITS-1:0] val,
                                       input logic [RADIX_W-1:0] rdx);
    logic [WORD_BITS-1:0] mag;
    logic [RADIX_W-1:0]   base;
    logic [RADIX_W-1:0]   digits[$];
    logic [RADIX_W-1:0]   d;
    logic                 neg;
    int                   total;
    base = rdx;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    // sign only in decimal; other radices see the raw bit pattern
    neg = (base == DECIMAL) && val[WORD_BITS-1];
    mag = neg ? (~val + 1'b1) : val;
    do begin
      digits.push_back(RADIX_W'(mag % base));
      mag = mag / base;
    end while (mag != 0);
    total = digits.size() + (neg ? 1 : 0);
    if (neg) push_char(CHR_MINUS, total == 1, total);
    for (int i = digits.size() - 1; i >= 0; i--) begin
      d = digits[i];
      push_char((d < DECIMAL) ? CHR_ZERO + CHAR_W'(d) : CHR_ALPHA + CHAR_W'(d - DECIMAL),
                i == 0, total);
    end
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) predict_text(value, radix);
      // hold a stalled request; otherwise advance or idle
      if (!item_valid || !item_stall) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          item_valid <= 1'b1;
          value      <= next_req.value;
          radix      <= next_req.radix;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Character monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (char_valid && !char_stall) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected character", 0, char_code);
        end else begin
          want_char = expected_chars.pop_front();
          if (char_code !== want_char.code)
            report_mismatch("char_code", want_char.code, char_code);
          if (last_char !== want_char.last)
            report_mismatch("last_char", want_char.last, last_char);
          if (text_length !== want_char.length)
            report_mismatch("text_length", want_char.length, text_length);
        end
      end
      char_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("integer_to_radix_string test failed");
      $finish;
    end
  end

  task automatic add_request(input logic [WORD_BITS-1:0] v, input logic [RADIX_W-1:0] r);
    request_t q;
    q.value = v;
    q.radix = r;
    pending_requests.push_back(q);
  endtask

  task automatic add_random_requests(input int count);
    logic [WORD_BITS-1:0] v;
    logic [RADIX_W-1:0]   r;
    int                   pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)      v = $urandom;
      else if (pick < 60) v = $urandom_range(999);
      else if (pick < 80) v = $urandom >> $urandom_range(31);
      else                v = -$urandom_range(1000);
      pick = $urandom_range(99);
      if (pick < 15)      r = DECIMAL;
      else if (pick < 85) r = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
      else                r = RADIX_W'($urandom_range(63));
      add_request(v, r);
    end
  endtask

  // Pause until every queued request has gone out and all text has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || item_valid || expected_chars.size() != 0);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    add_random_requests(PHASE_ITEMS);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // extremes, radix clamping, zero and the decimal sign
    add_request(0, DECIMAL);
    add_request(0, RADIX_MIN);
    add_request(0, RADIX_MAX);
    add_request(32'h8000_0000, DECIMAL);
    add_request(32'h7FFF_FFFF, DECIMAL);
    add_request(32'hFFFF_FFFF, DECIMAL);
    add_request(32'hFFFF_FFFF, RADIX_MIN);
    add_request(32'hFFFF_FFFF, 16);
    add_request(32'hFFFF_FFFF, RADIX_MAX);
    add_request(32'h8000_0000, RADIX_MIN);
    add_request(32'h7FFF_FFFF, RADIX_MAX);
    add_request(35, RADIX_MAX);
    add_request(10, 16);
    add_request(9, DECIMAL);
    add_request(-9, DECIMAL);
    add_request(-5, 8);
    add_request(7, 0);
    add_request(7, 1);
    add_request(100, 37);
    add_request(100, 63);
    add_request(32'hFFFF_FFFF, 63);
    add_request(1, 3);
    add_request(12345, DECIMAL);
    add_request(-100, 16);
    wait_drained();

    run_random_phase(0, 0);
    run_random_phase(47, 0);
    run_random_phase(0, 47);
    run_random_phase(28, 28);

    recv_stall_pct = 0;
    repeat (SETTLE_TICKS) @(posedge clk);
    if (mismatches == 0) begin
      $display("integer_to_radix_string test passed");
    end else begin
      $display("integer_to_radix_string test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
